@@ rtl/hwf_pkg.sv @@
// Package with the shared constants and types of the Hampel window filter.
package hwf_pkg;
  localparam int WINDOW_DEF = 5;
  localparam int SAMPLE_W = 16;
  localparam int POS_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_POS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_POS = 1'b1;
  localparam logic ACT_APPLY = 1'b0;
  localparam logic ACT_PASS = 1'b1;
  localparam logic [POS_W-1:0] FIRST_POS_RST = 3'd2;
  localparam logic [POS_W-1:0] LAST_POS_RST = 3'd2;

  typedef struct packed {
    logic             action;
    logic signed [15:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] filtered;
  } out_word_t;
endpackage

@@ rtl/hwf_stream_if.sv @@
// Valid/ready channel interface carrying one payload word.
interface hwf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/hampel_window_filter_core.sv @@
// Hampel window filter: sample window, serial sorts, gating and range mean.
// An apply word spends most of its time in four insertion sorts on one comparator
// and a 20-step divider for the range mean; a pass word, and the first word after
// reset if it is an apply, skip both. Input is taken only when idle, and a held
// result stalls only a finished apply.
// Synchronous active-low reset clears window, pointer and started flag; positions load 2.
module hampel_window_filter_core #(
  parameter int WINDOW = hwf_pkg::WINDOW_DEF
) (
  input  logic clk,
  input  logic rst_n,
  hwf_stream_if.sink   in_ch,
  hwf_stream_if.source out_ch,
  input  logic                            cfg_we,
  input  logic [hwf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hwf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  localparam int IW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW - 1);
  localparam logic [IW-1:0] MID_LO = IW'((WINDOW - 1) / 2);
  localparam logic [IW-1:0] MID_HI = IW'(WINDOW / 2);
  localparam logic [IW-1:0] HALF_CNT = IW'(WINDOW / 2);
  localparam bit ODD = (WINDOW % 2) == 1;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_COPY, S_SORT_KEY, S_SORT_CMP, S_MED, S_DEV, S_GATE,
    S_LO, S_HI, S_RANGE, S_SUM, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  logic signed [15:0] win_r [WINDOW];
  logic signed [17:0] buf_r [WINDOW];
  logic [IW-1:0] wp_r, i_r, j_r, f_r, l_r;
  logic          j_neg_r;
  logic          started_r, phase_r, sort2_r;
  logic [2:0]    first_r, last_r;
  logic signed [17:0] key_r, med_r;
  logic signed [19:0] lo_r, hi_r;
  logic signed [15:0] smp_r;
  logic signed [19:0] acc_r;
  logic [19:0]        rem_r, quo_r;
  logic [CW-1:0]      n_r;
  logic [4:0]         bit_r;
  logic               neg_r;
  logic signed [15:0] res_r;
  logic               ovalid_r;

  logic signed [17:0] cur;
  logic signed [18:0] msum;
  logic signed [17:0] mval;
  logic [20:0]        trial;
  logic               out_free;
  assign cur = buf_r[j_r];
  assign msum = 19'(buf_r[MID_LO]) + 19'(buf_r[MID_HI]);
  assign mval = ODD ? buf_r[MID_LO] : 18'(msum / 2);
  assign trial = {rem_r, acc_r[19 - bit_r]};
  assign out_free = !ovalid_r || out_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.data.filtered = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r <= '0;
      started_r <= 1'b0;
      first_r <= hwf_pkg::FIRST_POS_RST;
      last_r <= hwf_pkg::LAST_POS_RST;
      ovalid_r <= 1'b0;
      for (int k = 0; k < WINDOW; k++) win_r[k] <= '0;
    end else begin
      if (cfg_we && cfg_index == hwf_pkg::REG_FIRST_POS) first_r <= cfg_wdata;
      if (cfg_we && cfg_index == hwf_pkg::REG_LAST_POS) last_r <= cfg_wdata;
      // A new result loads in S_OUT in the same cycle the held word leaves.
      if (out_ch.valid && out_ch.ready && state_r != S_OUT) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            smp_r <= in_ch.data.sample;
            i_r <= '0;
            if (in_ch.data.action == hwf_pkg::ACT_PASS || started_r) begin
              started_r <= 1'b1;
              win_r[wp_r] <= in_ch.data.sample;
              wp_r <= (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
              state_r <= (in_ch.data.action == hwf_pkg::ACT_PASS) ? S_IDLE : S_COPY;
            end else begin
              started_r <= 1'b1;
              state_r <= S_FILL;
            end
          end
        end
        S_FILL: begin
          win_r[i_r] <= smp_r;
          i_r <= i_r + 1'b1;
          if (i_r == LAST_IDX) begin
            quo_r <= 20'(smp_r);
            state_r <= S_OUT;
          end
        end
        S_COPY: begin
          buf_r[i_r] <= 18'(win_r[i_r]);
          i_r <= i_r + 1'b1;
          if (i_r == LAST_IDX) begin
            i_r <= IW'(1);
            phase_r <= 1'b0;
            sort2_r <= 1'b0;
            state_r <= S_SORT_KEY;
          end
        end
        S_SORT_KEY: begin
          key_r <= buf_r[i_r];
          j_r <= i_r - 1'b1;
          j_neg_r <= 1'b0;
          state_r <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          if (!j_neg_r && cur > key_r) begin
            buf_r[j_r + 1'b1] <= cur;
            if (j_r == '0) j_neg_r <= 1'b1;
            else j_r <= j_r - 1'b1;
          end else begin
            buf_r[j_neg_r ? '0 : j_r + 1'b1] <= key_r;
            if (i_r == LAST_IDX) begin
              state_r <= S_MED;
            end else begin
              i_r <= i_r + 1'b1;
              state_r <= S_SORT_KEY;
            end
          end
        end
        S_MED: begin
          i_r <= '0;
          if (!phase_r && !sort2_r) begin
            med_r <= mval;
            state_r <= S_DEV;
          end else if (!sort2_r) begin
            lo_r <= 20'(med_r) - 20'(mval) * 20'sd3;
            hi_r <= 20'(med_r) + 20'(mval) * 20'sd3;
            state_r <= S_GATE;
          end else begin
            state_r <= S_RANGE;
          end
        end
        S_DEV: begin
          buf_r[i_r] <= (buf_r[i_r] > med_r) ? buf_r[i_r] - med_r : med_r - buf_r[i_r];
          i_r <= i_r + 1'b1;
          if (i_r == LAST_IDX) begin
            i_r <= IW'(1);
            phase_r <= 1'b1;
            state_r <= S_SORT_KEY;
          end
        end
        S_GATE: begin
          // Reload the working copy from the window, to be sorted again before gating.
          buf_r[i_r] <= 18'(win_r[i_r]);
          i_r <= i_r + 1'b1;
          if (i_r == LAST_IDX) begin
            i_r <= IW'(1);
            phase_r <= 1'b0;
            sort2_r <= 1'b1;
            state_r <= S_SORT_KEY;
          end
        end
        S_RANGE: begin
          if (!phase_r) begin
            // The first pass here applies the gate, then sorts again.
            phase_r <= 1'b1;
            i_r <= '0;
            state_r <= S_LO;
          end else begin
            if (int'(first_r) >= WINDOW) begin
              f_r <= MID_LO;
              l_r <= MID_HI;
            end else begin
              f_r <= IW'(first_r);
              l_r <= (int'(last_r) >= WINDOW) ? IW'(first_r) : IW'(last_r);
            end
            state_r <= S_SUM;
            i_r <= '0;
            acc_r <= '0;
          end
        end
        S_LO: begin
          if (i_r != HALF_CNT && 20'(buf_r[i_r]) < lo_r) begin
            buf_r[i_r] <= med_r;
            i_r <= i_r + 1'b1;
          end else begin
            i_r <= LAST_IDX;
            state_r <= S_HI;
          end
        end
        S_HI: begin
          if (i_r > MID_LO && 20'(buf_r[i_r]) > hi_r) begin
            buf_r[i_r] <= med_r;
            i_r <= i_r - 1'b1;
          end else begin
            i_r <= IW'(1);
            sort2_r <= 1'b1;
            phase_r <= 1'b1;
            state_r <= S_SORT_KEY;
          end
        end
        S_SUM: begin
          if (i_r == '0) begin
            if (f_r > l_r) begin
              f_r <= l_r;
              l_r <= f_r;
            end
            i_r <= i_r + 1'b1;
          end else begin
            j_r <= f_r;
            n_r <= CW'(l_r - f_r) + 1'b1;
            state_r <= S_DIV;
            bit_r <= '0;
            rem_r <= '0;
            quo_r <= '0;
            i_r <= '0;
          end
        end
        S_DIV: begin
          if (!i_r[0]) begin
            acc_r <= acc_r + 20'(buf_r[j_r]);
            if (j_r == l_r) i_r <= IW'(1);
            else j_r <= j_r + 1'b1;
          end else begin
            if (bit_r == '0 && rem_r == '0 && quo_r == '0 && acc_r[19]) begin
              acc_r <= -acc_r;
              neg_r <= 1'b1;
            end else begin
              if (bit_r == '0) neg_r <= neg_r & 1'b1;
              if (trial >= 21'(n_r)) begin
                rem_r <= 20'(trial - 21'(n_r));
                quo_r <= {quo_r[18:0], 1'b1};
              end else begin
                rem_r <= 20'(trial);
                quo_r <= {quo_r[18:0], 1'b0};
              end
              bit_r <= bit_r + 1'b1;
              if (bit_r == 5'd19) state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            res_r <= neg_r ? 16'(-quo_r) : 16'(quo_r);
            ovalid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_IDLE) neg_r <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.data.action == hwf_pkg::ACT_APPLY)
      |=> !in_ch.ready)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(res_r)))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= LAST_IDX)
    else $error("write pointer out of range");
endmodule
